// ===== rtl/cell_metric_anomaly_detector_top_macros.svh =====
// Assertion macros shared by the anomaly detector RTL.
// Used by the controller and the datapath; needs clk and rst in scope.
`ifndef CELL_METRIC_ANOMALY_DETECTOR_TOP_MACROS_SVH
`define CELL_METRIC_ANOMALY_DETECTOR_TOP_MACROS_SVH

// same-cycle implication, quiet during reset
`define CMAD_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, quiet during reset
`define CMAD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/cmad_pkg.sv =====
// Shared types, codes and helpers of the cell metric anomaly detector.
// No dependencies.
`default_nettype none
package cmad_pkg;

  // register indexes of the configuration port
  typedef enum logic [2:0] {
    REG_PERIOD      = 3'd0,
    REG_SAT_CONFIRM = 3'd1,
    REG_BURST_THR   = 3'd2,
    REG_COLLAPSE    = 3'd3,
    REG_RECOVERY    = 3'd4
  } reg_idx_t;

  // alert kinds
  localparam logic [2:0] KIND_NONE   = 3'd0;
  localparam logic [2:0] KIND_UL_SAT = 3'd1;
  localparam logic [2:0] KIND_DL_SAT = 3'd2;
  localparam logic [2:0] KIND_STORM  = 3'd3;
  localparam logic [2:0] KIND_RADIO  = 3'd4;
  localparam logic [2:0] KIND_BURST  = 3'd5;

  // severity codes
  localparam logic [1:0] SEV_NONE     = 2'd0;
  localparam logic [1:0] SEV_WARNING  = 2'd1;
  localparam logic [1:0] SEV_CRITICAL = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOAD,
    ST_SCAN,
    ST_FLAT1,
    ST_FLAT2,
    ST_DECIDE
  } state_t;

  typedef struct packed {
    logic [15:0] window_ms;
    logic [31:0] saturation_confirm_ms;
    logic [4:0]  burst_on_threshold;
    logic [7:0]  collapse_confirm_windows;
    logic [31:0] recovery_confirm_ms;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic load;
    logic scan;
    logic flat1;
    logic flat2;
    logic decide;
  } cmd_t;

  typedef struct packed {
    logic scan_done;
    logic out_busy;
  } status_t;

  // saturating run counter, cleared when the condition drops
  function automatic logic [7:0] bump(input logic [7:0] c, input logic cond);
    logic [7:0] r;
    r = 8'd0;
    if (cond) r = (c != 8'hFF) ? c + 8'd1 : 8'hFF;
    return r;
  endfunction

  // elapsed time, negative differences read as zero
  function automatic logic [47:0] elapsed(input logic [47:0] now, input logic [47:0] then);
    logic [47:0] r;
    r = (now >= then) ? now - then : 48'd0;
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/cell_metric_anomaly_detector_top.sv =====
// Top level of the cell metric anomaly detector: registers, sequencer, datapath.
// Depends on cmad_pkg, cmad_regs, cmad_ctrl and cmad_dp.
//
//   channel | direction | handshake            | word
//   in      | input     | in_valid / in_stall   | one metrics window, nine fields
//   out     | output    | out_valid / out_stall | one verdict, six fields
//   cfg     | input     | psel/penable/pwrite   | 32-bit register write or read
//
// An item is accepted, loaded, scanned over SCAN_LEN entries, run through the flatline
// steps FLAT1 and FLAT2 and decided, with SCAN_LEN the largest of VAR_WINDOW, RACH_DEPTH
// and BURST_SLOTS (16 by default); the next word is taken only once the item is decided.
// The scan is single-entry, over the history windows and burst ring.
// Reset is synchronous and clears the history but for the burst timestamps, unused at count zero.
// A stalled verdict holds in the output register; the next item still runs up to it.
`default_nettype none
module cell_metric_anomaly_detector_top
  import cmad_pkg::*;
#(
  parameter int VAR_WINDOW          = 10,
  parameter int RACH_DEPTH          = 10,
  parameter int BURST_SLOTS         = 16,
  parameter int BURST_DECAY_WINDOWS = 300,
  parameter int STORM_BURSTS        = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [14:0] prb_ul,
  input  wire logic [14:0] prb_dl,
  input  wire logic [31:0] rlc_volume_dl,
  input  wire logic [31:0] rlc_volume_ul,
  input  wire logic [3:0]  cqi_value,
  input  wire logic [15:0] rach_count,
  input  wire logic [15:0] empty_indications,
  input  wire logic [15:0] uplink_air_delay,
  input  wire logic [47:0] time_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       severity,
  output logic             first_alert,
  output logic             critical_flag,
  output logic [2:0]       alert_kind,
  output logic [47:0]      first_latency_ms,
  output logic [47:0]      stage2_confirm_time_ms
);

  cfg_t    cfg;
  cmd_t    cmd;
  status_t status;

  cmad_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready, .cfg
  );

  cmad_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .status, .cmd
  );

  cmad_dp #(
    .VAR_WINDOW          (VAR_WINDOW),
    .RACH_DEPTH          (RACH_DEPTH),
    .BURST_SLOTS         (BURST_SLOTS),
    .BURST_DECAY_WINDOWS (BURST_DECAY_WINDOWS),
    .STORM_BURSTS        (STORM_BURSTS)
  ) u_dp (
    .clk, .rst, .cmd, .status, .cfg,
    .prb_ul, .prb_dl, .rlc_volume_dl, .rlc_volume_ul, .cqi_value,
    .rach_count, .empty_indications, .uplink_air_delay, .time_ms,
    .out_valid, .out_stall,
    .severity, .first_alert, .critical_flag, .alert_kind,
    .first_latency_ms, .stage2_confirm_time_ms
  );

endmodule
`default_nettype wire

// ===== rtl/cmad_regs.sv =====
// Configuration register file on the APB-style port.
// Depends on cmad_pkg.
`default_nettype none
module cmad_regs
  import cmad_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [4:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  output cfg_t             cfg
);

  logic     wr_en;
  reg_idx_t idx;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = reg_idx_t'(paddr[4:2]);

  // write the addressed register, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.window_ms                <= 16'd100;
      cfg.saturation_confirm_ms    <= 32'd30000;
      cfg.burst_on_threshold       <= 5'd4;
      cfg.collapse_confirm_windows <= 8'd5;
      cfg.recovery_confirm_ms      <= 32'd5000;
    end else if (wr_en) begin
      case (idx)
        REG_PERIOD:      cfg.window_ms                <= pwdata[15:0];
        REG_SAT_CONFIRM: cfg.saturation_confirm_ms    <= pwdata;
        REG_BURST_THR:   cfg.burst_on_threshold       <= pwdata[4:0];
        REG_COLLAPSE:    cfg.collapse_confirm_windows <= pwdata[7:0];
        REG_RECOVERY:    cfg.recovery_confirm_ms      <= pwdata;
        default: ;
      endcase
    end
  end

  // read back
  always_comb begin
    case (idx)
      REG_PERIOD:      prdata = {16'd0, cfg.window_ms};
      REG_SAT_CONFIRM: prdata = cfg.saturation_confirm_ms;
      REG_BURST_THR:   prdata = {27'd0, cfg.burst_on_threshold};
      REG_COLLAPSE:    prdata = {24'd0, cfg.collapse_confirm_windows};
      REG_RECOVERY:    prdata = cfg.recovery_confirm_ms;
      default:         prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

// ===== rtl/cmad_ctrl.sv =====
// Sequencer: capture, load, scan, flatline math, decide.
// Depends on cmad_pkg and the assertion macros header.
`default_nettype none
`include "cell_metric_anomaly_detector_top_macros.svh"
module cmad_ctrl
  import cmad_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst,
  input  wire logic    in_valid,
  output logic         in_stall,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE:   if (in_valid) state_next = ST_LOAD;
      ST_LOAD:   state_next = ST_SCAN;
      ST_SCAN:   if (status.scan_done) state_next = ST_FLAT1;
      ST_FLAT1:  state_next = ST_FLAT2;
      ST_FLAT2:  state_next = ST_DECIDE;
      ST_DECIDE: if (!status.out_busy) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_stall = 1'b1;
    case (state)
      ST_IDLE: begin
        in_stall    = 1'b0;
        cmd.capture = in_valid;
      end
      ST_LOAD:   cmd.load   = 1'b1;
      ST_SCAN:   cmd.scan   = 1'b1;
      ST_FLAT1:  cmd.flat1  = 1'b1;
      ST_FLAT2:  cmd.flat2  = 1'b1;
      ST_DECIDE: cmd.decide = !status.out_busy;
      default: ;
    endcase
  end

  `CMAD_ASSERT_NEXT(a_capture_loads, cmd.capture, state == ST_LOAD, "capture did not load")
  `CMAD_ASSERT_NEXT(a_scan_ends, cmd.scan && status.scan_done, cmd.flat1, "scan overran")
  `CMAD_ASSERT_NEXT(a_decide_frees, cmd.decide, !in_stall, "input not freed after decide")

endmodule
`default_nettype wire

// ===== rtl/cmad_dp.sv =====
// Datapath: history windows, burst ring, flatline math, alert rules, result word.
// Depends on cmad_pkg and the assertion macros header.
`default_nettype none
`include "cell_metric_anomaly_detector_top_macros.svh"
module cmad_dp
  import cmad_pkg::*;
#(
  parameter int VAR_WINDOW          = 10,
  parameter int RACH_DEPTH          = 10,
  parameter int BURST_SLOTS         = 16,
  parameter int BURST_DECAY_WINDOWS = 300,
  parameter int STORM_BURSTS        = 3
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire cmd_t        cmd,
  output status_t          status,
  input  wire cfg_t        cfg,
  input  wire logic [14:0] prb_ul,
  input  wire logic [14:0] prb_dl,
  input  wire logic [31:0] rlc_volume_dl,
  input  wire logic [31:0] rlc_volume_ul,
  input  wire logic [3:0]  cqi_value,
  input  wire logic [15:0] rach_count,
  input  wire logic [15:0] empty_indications,
  input  wire logic [15:0] uplink_air_delay,
  input  wire logic [47:0] time_ms,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [1:0]       severity,
  output logic             first_alert,
  output logic             critical_flag,
  output logic [2:0]       alert_kind,
  output logic [47:0]      first_latency_ms,
  output logic [47:0]      stage2_confirm_time_ms
);

  localparam int VIW = $clog2(VAR_WINDOW);
  localparam int NW  = $clog2(VAR_WINDOW + 1);
  localparam int SW  = 15 + NW;
  localparam int QW  = 30 + NW;
  localparam int PW  = NW + QW;
  localparam int XW  = PW + 14;
  localparam int LW  = 2 * NW + 16;
  localparam int RIW = $clog2(RACH_DEPTH);
  localparam int RSW = 16 + $clog2(RACH_DEPTH + 1);
  localparam int RMW = RSW + 2;
  localparam int BIW = $clog2(BURST_SLOTS);
  localparam int BCW = $clog2(BURST_SLOTS + 1);
  localparam int WSW = $clog2(BURST_DECAY_WINDOWS + 2);
  localparam int SCAN_LEN = (VAR_WINDOW > RACH_DEPTH) ?
                            ((VAR_WINDOW > BURST_SLOTS) ? VAR_WINDOW : BURST_SLOTS) :
                            ((RACH_DEPTH > BURST_SLOTS) ? RACH_DEPTH : BURST_SLOTS);
  localparam int SCW = $clog2(SCAN_LEN + 1);

  // captured word
  logic [14:0] ul_c, dl_c;
  logic [31:0] vdl_c, vul_c;
  logic [3:0]  cqi_c;
  logic [15:0] rach_c, empty_c, delay_c;
  logic [47:0] now_c;

  // histories
  logic [14:0]    ul_win [VAR_WINDOW];
  logic [14:0]    dl_win [VAR_WINDOW];
  logic [VIW-1:0] win_pos;
  logic [NW-1:0]  win_fill;
  logic [15:0]    rach_ring [RACH_DEPTH];
  logic [RIW-1:0] rach_pos;
  logic [47:0]    burst_times [BURST_SLOTS];
  logic [BIW-1:0] burst_pos, burst_slot;
  logic [BCW-1:0] burst_cnt;
  logic           burst_was_on;
  logic [47:0]    burst_until;

  // run counters and tracking
  logic [7:0]     ul_sat_run, dl_sat_run, storm_run, empty_run, collapse_run;
  logic [15:0]    prev_total;
  logic [7:0]     rrc_bursts;
  logic [WSW-1:0] since_burst;
  logic           prev_in_burst;
  logic [47:0]    sat_start, rec_start, s1_start, s2_time;
  logic           s1_active, s2_seen;

  // scan accumulators
  logic [SCW-1:0] scan_k;
  logic [SW-1:0]  s_ul, s_dl;
  logic [QW-1:0]  q_ul, q_dl;
  logic [RSW-1:0] rsum;
  logic [BCW-1:0] live_cnt;
  logic [47:0]    latest;

  // flatline pipeline
  logic [PW-1:0] nq_ul, nq_dl, ss_ul, ss_dl;
  logic [XW-1:0] x_ul, x_dl;
  logic [LW-1:0] nn;

  // load-phase helpers
  logic           burst_on;
  logic [BIW-1:0] burst_pos_next;
  logic [BCW-1:0] burst_cnt_load;

  assign burst_on = (ul_c > 15'd17920) && (dl_c < 15'd5120);
  assign burst_pos_next = (burst_on && !burst_was_on) ?
                          ((burst_pos == BIW'(BURST_SLOTS - 1)) ? '0 : burst_pos + 1'b1) :
                          burst_pos;
  assign burst_cnt_load = (burst_on && !burst_was_on && burst_cnt != BCW'(BURST_SLOTS)) ?
                          burst_cnt + 1'b1 : burst_cnt;

  assign status.scan_done = (scan_k == SCW'(SCAN_LEN - 1));
  assign status.out_busy  = out_valid && out_stall;

  // capture the input word
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ul_c    <= prb_ul;
      dl_c    <= prb_dl;
      vdl_c   <= rlc_volume_dl;
      vul_c   <= rlc_volume_ul;
      cqi_c   <= cqi_value;
      rach_c  <= rach_count;
      empty_c <= empty_indications;
      delay_c <= uplink_air_delay;
      now_c   <= time_ms;
    end
  end

  // variance windows
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < VAR_WINDOW; i++) begin
        ul_win[i] <= '0;
        dl_win[i] <= '0;
      end
      win_pos  <= '0;
      win_fill <= '0;
    end else if (cmd.load) begin
      ul_win[win_pos] <= ul_c;
      dl_win[win_pos] <= dl_c;
      win_pos  <= (win_pos == VIW'(VAR_WINDOW - 1)) ? '0 : win_pos + 1'b1;
      if (win_fill != NW'(VAR_WINDOW)) win_fill <= win_fill + 1'b1;
    end
  end

  // ON-burst timestamp ring
  always_ff @(posedge clk) begin
    if (cmd.load && burst_on && !burst_was_on) burst_times[burst_pos] <= now_c;
  end

  // scan: window sums, RACH sum, live burst entries (newest first)
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      scan_k     <= '0;
      s_ul       <= '0;
      s_dl       <= '0;
      q_ul       <= '0;
      q_dl       <= '0;
      rsum       <= '0;
      live_cnt   <= '0;
      latest     <= '0;
      burst_slot <= (burst_pos_next == '0) ? BIW'(BURST_SLOTS - 1) : burst_pos_next - 1'b1;
    end else if (cmd.scan) begin
      scan_k     <= scan_k + 1'b1;
      burst_slot <= (burst_slot == '0) ? BIW'(BURST_SLOTS - 1) : burst_slot - 1'b1;
      if (32'(scan_k) < VAR_WINDOW) begin
        s_ul <= s_ul + SW'(ul_win[scan_k[VIW-1:0]]);
        s_dl <= s_dl + SW'(dl_win[scan_k[VIW-1:0]]);
        q_ul <= q_ul + QW'(ul_win[scan_k[VIW-1:0]]) * QW'(ul_win[scan_k[VIW-1:0]]);
        q_dl <= q_dl + QW'(dl_win[scan_k[VIW-1:0]]) * QW'(dl_win[scan_k[VIW-1:0]]);
      end
      if (32'(scan_k) < RACH_DEPTH) rsum <= rsum + RSW'(rach_ring[scan_k[RIW-1:0]]);
      if (32'(scan_k) < 32'(burst_cnt) &&
          elapsed(now_c, burst_times[burst_slot]) <= 48'd90000) begin
        live_cnt <= live_cnt + 1'b1;
        if (burst_times[burst_slot] > latest) latest <= burst_times[burst_slot];
      end
    end
  end

  // flatline: n*Q and S*S, then scale
  always_ff @(posedge clk) begin
    if (cmd.flat1) begin
      nq_ul <= PW'(win_fill) * PW'(q_ul);
      nq_dl <= PW'(win_fill) * PW'(q_dl);
      ss_ul <= PW'(s_ul) * PW'(s_ul);
      ss_dl <= PW'(s_dl) * PW'(s_dl);
    end
    if (cmd.flat2) begin
      x_ul <= XW'(nq_ul - ss_ul) * XW'(14'd10000);
      x_dl <= XW'(nq_dl - ss_dl) * XW'(14'd10000);
      nn   <= {LW'(win_fill) * LW'(win_fill)} << 16;
    end
  end

  // alert rules
  logic [15:0]    total;
  logic [35:0]    vul10, vdl10;
  logic           hit, ul_flat, dl_flat, in_burst, burst_live;
  logic [2:0]     kind;
  logic [1:0]     sev;
  logic [7:0]     ul_run_n, dl_run_n, storm_run_n, empty_run_n, collapse_run_n, rrc_n;
  logic [WSW-1:0] since_n;
  logic [48:0]    cand;
  logic [47:0]    until_n, sat_start_n, rec_start_n, s1_start_n, s2_time_n, sat_dur;
  logic           s1_active_n, s2_seen_n;
  logic [47:0]    lat, conf;

  always_comb begin
    total   = 16'(ul_c) + 16'(dl_c);
    vul10   = 36'(vul_c) * 36'd10;
    vdl10   = 36'(vdl_c) * 36'd10;
    ul_flat = XW'(nn) > x_ul;
    dl_flat = XW'(nn) > x_dl;
    hit     = 1'b0;
    kind    = KIND_NONE;
    sev     = SEV_NONE;

    ul_run_n = bump(ul_sat_run, (ul_c > 15'd20480) && (dl_c < 15'd3840));
    if (ul_run_n >= 8'd5) begin
      hit = 1'b1; kind = KIND_UL_SAT; sev = SEV_WARNING;
    end
    dl_run_n = bump(dl_sat_run, (dl_c > 15'd20480) && (ul_c < 15'd7680));
    if (dl_run_n >= 8'd3 && !hit) begin
      hit = 1'b1; kind = KIND_DL_SAT; sev = SEV_WARNING;
    end

    storm_run_n = bump(storm_run, (total > 16'd10240) &&
                       (vul10 < 36'(cfg.window_ms)) && (vdl10 < 36'(cfg.window_ms)) &&
                       (dl_c < 15'd20480) && (ul_c < 15'd20480) &&
                       ((cqi_c < 4'd5) || (rach_c != 16'd0)));
    if (storm_run_n >= 8'd3) begin
      if (!hit) begin hit = 1'b1; kind = KIND_STORM; end
      if (sev == SEV_NONE) sev = SEV_WARNING;
    end

    // RACH spike against the rolling mean
    if ((rach_c > 16'd5) &&
        (RMW'(rach_c) * RMW'(RACH_DEPTH) > RMW'(3) * (RMW'(rsum) + RMW'(RACH_DEPTH)))) begin
      if (!hit) begin hit = 1'b1; kind = KIND_STORM; end
      if (sev == SEV_NONE) sev = SEV_WARNING;
    end

    // empty-indication bursts
    since_n = since_burst;
    rrc_n   = rrc_bursts;
    if ((empty_c >= 16'd2) && (ul_c < 15'd7680) && (dl_c < 15'd7680)) begin
      empty_run_n = bump(empty_run, 1'b1);
    end else begin
      if (prev_in_burst && empty_run >= 8'd3) since_n = '0;
      empty_run_n = 8'd0;
    end
    in_burst = empty_run_n >= 8'd3;
    if (in_burst) begin
      if (!hit) begin hit = 1'b1; kind = KIND_STORM; end
      if (sev == SEV_NONE) sev = SEV_WARNING;
    end
    if (in_burst && !prev_in_burst) begin
      if (since_n > WSW'(BURST_DECAY_WINDOWS)) rrc_n = 8'd0;
      if (rrc_n != 8'hFF) rrc_n = rrc_n + 8'd1;
      since_n = '0;
    end
    if (!in_burst && since_n < WSW'(BURST_DECAY_WINDOWS + 1)) since_n = since_n + 1'b1;
    if (rrc_n >= 8'(STORM_BURSTS)) sev = SEV_CRITICAL;

    // air delay
    if (delay_c > 16'd100) begin
      if (!hit) begin hit = 1'b1; kind = KIND_RADIO; end
      if (sev == SEV_NONE) sev = SEV_WARNING;
    end

    // resource collapse
    collapse_run_n = bump(collapse_run, (prev_total > 16'd10240) && (total < 16'd1280) &&
                          (delay_c == 16'd0));
    if (collapse_run_n >= 8'd2 && !hit) begin
      hit = 1'b1; kind = KIND_RADIO;
      if (sev == SEV_NONE) sev = SEV_WARNING;
    end
    if (collapse_run_n >= cfg.collapse_confirm_windows) sev = SEV_CRITICAL;

    // periodic ON bursts
    until_n = burst_until;
    cand    = {1'b0, latest} + 49'd15000;
    if (live_cnt >= BCW'(2)) begin
      if (cand[48]) cand = {1'b0, {48{1'b1}}};
      if (cand[47:0] > burst_until) until_n = cand[47:0];
    end
    burst_live = (until_n != 48'd0) && (now_c <= until_n);
    if (burst_live && !hit) begin
      hit = 1'b1; kind = KIND_BURST;
      if (sev == SEV_NONE) sev = SEV_WARNING;
    end
    if (burst_live && 32'(live_cnt) >= 32'(cfg.burst_on_threshold)) sev = SEV_CRITICAL;

    // saturation duration and recovery
    sat_start_n = sat_start;
    rec_start_n = rec_start;
    sat_dur     = 48'd0;
    if (kind == KIND_UL_SAT || kind == KIND_DL_SAT) begin
      if (sat_start == 48'd0 || rec_start != 48'd0) sat_start_n = now_c;
      sat_dur     = elapsed(now_c, sat_start_n);
      rec_start_n = 48'd0;
      if (sat_dur >= 48'(cfg.saturation_confirm_ms)) sev = SEV_CRITICAL;
      if (sat_dur >= 48'd15000) begin
        if (kind == KIND_UL_SAT && ul_flat && ul_c > 15'd20480) sev = SEV_CRITICAL;
        if (kind == KIND_DL_SAT && dl_flat && dl_c > 15'd20480) sev = SEV_CRITICAL;
      end
    end else if (sat_start != 48'd0) begin
      if (rec_start == 48'd0) rec_start_n = now_c;
      if (elapsed(now_c, rec_start_n) >= 48'(cfg.recovery_confirm_ms)) begin
        sat_start_n = 48'd0;
        rec_start_n = 48'd0;
      end
    end

    // stage tracking
    s1_start_n  = s1_start;
    s1_active_n = s1_active;
    s2_time_n   = s2_time;
    s2_seen_n   = s2_seen;
    if (hit) begin
      if (!s1_active) s1_start_n = now_c;
      s1_active_n = 1'b1;
    end else if (s1_active) begin
      s1_start_n  = 48'd0;
      s1_active_n = 1'b0;
      s2_time_n   = 48'd0;
      s2_seen_n   = 1'b0;
    end
    if (sev == SEV_CRITICAL && !s2_seen_n) begin
      s2_time_n = now_c;
      s2_seen_n = 1'b1;
    end
    if (sev != SEV_CRITICAL) begin
      s2_seen_n = 1'b0;
      s2_time_n = 48'd0;
    end

    lat  = (hit && s1_start_n != 48'd0) ? elapsed(now_c, s1_start_n) : 48'd0;
    conf = (sev == SEV_CRITICAL && s2_time_n != 48'd0 && s1_start_n != 48'd0) ?
           elapsed(s2_time_n, s1_start_n) : 48'd0;
  end

  // commit state at decide; burst ring bookkeeping at load
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < RACH_DEPTH; i++) rach_ring[i] <= '0;
      rach_pos      <= '0;
      ul_sat_run    <= '0;
      dl_sat_run    <= '0;
      storm_run     <= '0;
      empty_run     <= '0;
      collapse_run  <= '0;
      prev_total    <= '0;
      rrc_bursts    <= '0;
      since_burst   <= '0;
      prev_in_burst <= 1'b0;
      burst_pos     <= '0;
      burst_cnt     <= '0;
      burst_was_on  <= 1'b0;
      burst_until   <= '0;
      sat_start     <= '0;
      rec_start     <= '0;
      s1_start      <= '0;
      s1_active     <= 1'b0;
      s2_time       <= '0;
      s2_seen       <= 1'b0;
    end else if (cmd.load) begin
      burst_pos    <= burst_pos_next;
      burst_cnt    <= burst_cnt_load;
      burst_was_on <= burst_on;
    end else if (cmd.decide) begin
      rach_ring[rach_pos] <= rach_c;
      rach_pos      <= (rach_pos == RIW'(RACH_DEPTH - 1)) ? '0 : rach_pos + 1'b1;
      ul_sat_run    <= ul_run_n;
      dl_sat_run    <= dl_run_n;
      storm_run     <= storm_run_n;
      empty_run     <= empty_run_n;
      collapse_run  <= collapse_run_n;
      prev_total    <= total;
      rrc_bursts    <= rrc_n;
      since_burst   <= since_n;
      prev_in_burst <= in_burst;
      burst_cnt     <= live_cnt;
      burst_until   <= until_n;
      sat_start     <= sat_start_n;
      rec_start     <= rec_start_n;
      s1_start      <= s1_start_n;
      s1_active     <= s1_active_n;
      s2_time       <= s2_time_n;
      s2_seen       <= s2_seen_n;
    end
  end

  // result word: hold until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.decide) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.decide) begin
      severity               <= sev;
      first_alert            <= hit;
      critical_flag          <= (sev == SEV_CRITICAL);
      alert_kind             <= kind;
      first_latency_ms       <= lat;
      stage2_confirm_time_ms <= conf;
    end
  end

  `CMAD_ASSERT_NEXT(a_decide_shows, cmd.decide, out_valid, "decided word not shown")
  `CMAD_ASSERT_NOW(a_ring_count, 1'b1, 32'(burst_cnt) <= BURST_SLOTS, "burst count overflow")
  `CMAD_ASSERT_NOW(a_no_overwrite, cmd.decide, !(out_valid && out_stall), "held word overwritten")

endmodule
`default_nettype wire
